@@ rtl/core/mps_pkg.sv @@
// Shared move codes, command codes, cell control word and fold function for the path store.
`default_nettype none

package mps_pkg;

  // Store geometry defaults and fixed field widths
  localparam int MAX_MOVES_DEF = 64;
  localparam int MOVE_W        = 2;
  localparam int MOVE_OUT_W    = 3;
  localparam int IDX_W         = 7;
  localparam int LEN_W         = 7;

  typedef logic [MOVE_W-1:0] move_t;

  // Move codes
  localparam move_t MV_STRAIGHT = 2'd0;
  localparam move_t MV_LEFT     = 2'd1;
  localparam move_t MV_RIGHT    = 2'd2;
  localparam move_t MV_BACK     = 2'd3;
  localparam logic [MOVE_OUT_W-1:0] MV_NONE = 3'd4;

  // Command codes
  localparam logic [1:0] CMD_RECORD   = 2'd0;
  localparam logic [1:0] CMD_SIMPLIFY = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;

  // Store chain operations
  localparam logic [1:0] SOP_HOLD = 2'd0;
  localparam logic [1:0] SOP_PUSH = 2'd1;
  localparam logic [1:0] SOP_FOLD = 2'd2;

  // Lane chain operations
  localparam logic [1:0] LOP_HOLD = 2'd0;
  localparam logic [1:0] LOP_LOAD = 2'd1;
  localparam logic [1:0] LOP_UP   = 2'd2;
  localparam logic [1:0] LOP_DOWN = 2'd3;

  // Control word broadcast to every cell
  typedef struct packed {
    logic [1:0] store_op;
    logic [1:0] lane_op;
  } cell_ctrl_t;

  // Clockwise heading change in quarter turns
  function automatic logic [1:0] quarter_turns(input move_t mv);
    logic [1:0] q;
    begin
      unique case (mv)
        MV_RIGHT: q = 2'd1;
        MV_BACK:  q = 2'd2;
        MV_LEFT:  q = 2'd3;
        default:  q = 2'd0;
      endcase
      return q;
    end
  endfunction

  // Collapse (a, back, b) into one move: a + half turn + b, modulo a full turn
  function automatic move_t fold_moves(input move_t a, input move_t b);
    logic [1:0] net;
    move_t      mv;
    begin
      net = quarter_turns(a) + 2'd2 + quarter_turns(b);
      unique case (net)
        2'd1:    mv = MV_RIGHT;
        2'd2:    mv = MV_BACK;
        2'd3:    mv = MV_LEFT;
        default: mv = MV_STRAIGHT;
      endcase
      return mv;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mps_cell.sv @@
// One cell of the path chain: a stored move plus a lane register for scanning it out.
`default_nettype none

module mps_cell
  import mps_pkg::*;
#(
  parameter bit HEAD = 1'b0
) (
  input  wire             clk,
  input  wire cell_ctrl_t ctrl,
  input  wire move_t      store_lo,
  input  wire move_t      store_hi,
  input  wire move_t      lane_lo,
  input  wire move_t      lane_hi,
  output move_t           store_q,
  output move_t           lane_q
);

  move_t store, store_next;
  move_t lane, lane_next;

  // Pick the stored move: push takes the lower neighbor, fold pulls from above except in the head cell
  always_comb begin
    store_next = store;
    unique case (ctrl.store_op)
      SOP_PUSH: store_next = store_lo;
      SOP_FOLD: store_next = HEAD ? store_lo : store_hi;
      default:  store_next = store;
    endcase
  end

  // Pick the lane value: load a snapshot or shift either way
  always_comb begin
    lane_next = lane;
    unique case (ctrl.lane_op)
      LOP_LOAD: lane_next = store;
      LOP_UP:   lane_next = lane_lo;
      LOP_DOWN: lane_next = lane_hi;
      default:  lane_next = lane;
    endcase
  end

  always_ff @(posedge clk) begin
    store <= store_next;
    lane  <= lane_next;
  end

  assign store_q = store;
  assign lane_q  = lane;

endmodule

`default_nettype wire

@@ rtl/core/maze_path_record_simplify_replay_core.sv @@
// Maze path store top level: command decode, sequencing and the row of move cells.
//
// Usage:
//   Commands enter on the s_ side (tuser = command, tdata = move and index);
//   every command returns one word on the m_ side with the move read (or none),
//   the path length and the sticky overflow flag.
//   Moves sit in a chain of MAX_MOVES cells, newest move in cell 0.
//   Record: one push into the chain.
//   Read at index i of n moves: the lane chain shifts the snapshot toward
//     cell 0 one place per cycle; out of range reads return no move.
//   Simplify: for a non-empty path the snapshot walks out of the top of the
//     lane chain one move per cycle, oldest first, and each move is pushed
//     back onto the store, folding with the two below it when the one just
//     below is a back move. An empty path is left as it is.
//   One command is in work at a time; a new one is taken as soon as the
//   previous one has finished, even while its result still waits in the
//   output register. If the receiver stalls, the finished command holds
//   until the output register frees up.
//   Reset empties the store and clears the overflow flag; no clearing pass.
`default_nettype none

module maze_path_record_simplify_replay_core
  import mps_pkg::*;
#(
  parameter int MAX_MOVES = MAX_MOVES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [1:0] move_in, [8:2] read_index, [15:9] zero
  input  wire  [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata    // [2:0] move_out, [9:3] path_length, [10] overflowed
);

  localparam int CW = $clog2(MAX_MOVES + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_MOVES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_FEED = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Control registers
  logic [2:0]            state, state_next;
  logic [CW-1:0]         count, count_next;
  logic                  overflow_latch, overflow_next;
  logic [CW-1:0]         step_cnt, step_next;
  logic [CW-1:0]         feed_cnt, feed_next;
  logic [MOVE_OUT_W-1:0] pend_move, pend_next;

  // Output register
  logic [MOVE_OUT_W-1:0] out_move;
  logic [LEN_W-1:0]      out_len;
  logic                  out_ovf;

  cell_ctrl_t ctrl;
  move_t      head_val;
  move_t      store_q [MAX_MOVES];
  move_t      lane_q  [MAX_MOVES];

  logic          s_accept;
  logic [1:0]    cmd;
  move_t         move_in;
  logic [XW-1:0] idx_x, count_x, dist_x;
  logic          out_load;
  move_t         feed_move;

  assign cmd      = s_tuser;
  assign move_in  = s_tdata[1:0];
  assign idx_x    = XW'(s_tdata[8:2]);
  assign count_x  = XW'(count);
  assign dist_x   = count_x - idx_x - XW'(1);
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid & s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign feed_move = lane_q[MAX_MOVES-1];

  // Sequence commands and drive the cell chain
  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow_latch;
    step_next     = step_cnt;
    feed_next     = feed_cnt;
    pend_next     = pend_move;
    ctrl.store_op = SOP_HOLD;
    ctrl.lane_op  = LOP_HOLD;
    head_val      = move_in;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          pend_next  = MV_NONE;
          state_next = ST_DONE;
          case (cmd)
            CMD_RECORD: begin
              if (count >= CAP) begin
                overflow_next = 1'b1;
              end else begin
                ctrl.store_op = SOP_PUSH;
                count_next    = count + 1'b1;
              end
            end
            CMD_SIMPLIFY: begin
              if (count != '0) begin
                ctrl.lane_op = LOP_LOAD;
                count_next   = '0;
                step_next    = CAP - count;
                feed_next    = count;
                state_next   = ST_SKIP;
              end
            end
            CMD_READ: begin
              if (idx_x < count_x) begin
                ctrl.lane_op = LOP_LOAD;
                step_next    = dist_x[CW-1:0];
                state_next   = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // Shift the snapshot down until the wanted move sits in cell 0
        if (step_cnt == '0) begin
          pend_next  = {1'b0, lane_q[0]};
          state_next = ST_DONE;
        end else begin
          ctrl.lane_op = LOP_DOWN;
          step_next    = step_cnt - 1'b1;
        end
      end
      ST_SKIP: begin
        // Advance the oldest move to the top of the lane
        if (step_cnt == '0) begin
          state_next = ST_FEED;
        end else begin
          ctrl.lane_op = LOP_UP;
          step_next    = step_cnt - 1'b1;
        end
      end
      ST_FEED: begin
        // Push the next move back, folding over a back move just below
        ctrl.lane_op = LOP_UP;
        if (count >= CW'(2) && store_q[0] == MV_BACK) begin
          ctrl.store_op = SOP_FOLD;
          head_val      = fold_moves(store_q[1], feed_move);
          count_next    = count - 1'b1;
        end else begin
          ctrl.store_op = SOP_PUSH;
          head_val      = feed_move;
          count_next    = count + 1'b1;
        end
        feed_next = feed_cnt - 1'b1;
        if (feed_cnt == CW'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      overflow_latch <= 1'b0;
      step_cnt       <= '0;
      feed_cnt       <= '0;
      pend_move      <= MV_NONE;
      m_tvalid       <= 1'b0;
    end else begin
      state          <= state_next;
      count          <= count_next;
      overflow_latch <= overflow_next;
      step_cnt       <= step_next;
      feed_cnt       <= feed_next;
      pend_move      <= pend_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Capture the finished word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_move <= pend_move;
      out_len  <= count_x[LEN_W-1:0];
      out_ovf  <= overflow_latch;
    end
  end

  assign m_tdata = {5'b0, out_ovf, out_len, out_move};

  // Row of cells, each linked to its lower and upper neighbor
  for (genvar k = 0; k < MAX_MOVES; k++) begin : g_cell
    move_t st_lo, st_hi, ln_lo, ln_hi;
    if (k == 0) begin : g_head
      assign st_lo = head_val;
      assign ln_lo = MV_STRAIGHT;
    end else begin : g_body
      assign st_lo = store_q[k-1];
      assign ln_lo = lane_q[k-1];
    end
    if (k == MAX_MOVES - 1) begin : g_tail
      assign st_hi = MV_STRAIGHT;
      assign ln_hi = MV_STRAIGHT;
    end else begin : g_inner
      assign st_hi = store_q[k+1];
      assign ln_hi = lane_q[k+1];
    end
    mps_cell #(
      .HEAD (k == 0)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .store_lo (st_lo),
      .store_hi (st_hi),
      .lane_lo  (ln_lo),
      .lane_hi  (ln_hi),
      .store_q  (store_q[k]),
      .lane_q   (lane_q[k])
    );
  end

  // The path never holds more moves than there are cells
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("path length beyond capacity");

  // Overflow stays set once raised
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_latch |=> overflow_latch)
    else $error("overflow flag dropped");

  // A record with room grows the path by exactly one
  a_rec_grows: assert property (@(posedge clk) disable iff (rst)
    (s_accept && cmd == CMD_RECORD && count < CAP) |=> (count == $past(count) + 1'b1))
    else $error("record did not append");

  // While rebuilding, stack plus moves still to come fit in the chain
  a_feed_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEED) |-> ({1'b0, count} + {1'b0, feed_cnt} <= {1'b0, CAP}))
    else $error("simplify rebuild exceeds capacity");

endmodule

`default_nettype wire

@@ verif/maze_path_record_simplify_replay_core_tb.sv @@
// Self-checking testbench for the maze path store: record, simplify and replay commands.

// One expected reply word, split into its fields
typedef struct packed {
  logic [2:0] move_read;
  logic [6:0] length;
  logic       overflow;
} path_reply_t;

// Mirror of the path store and the queue of reply words still owed by the block
class path_scoreboard;
  mps_pkg::move_t path_moves[mps_pkg::MAX_MOVES_DEF];
  int             path_len;
  bit             dropped_flag;
  path_reply_t    pending[$];
  int             errors;

  function new();
    path_len     = 0;
    dropped_flag = 1'b0;
    errors       = 0;
    foreach (path_moves[i]) path_moves[i] = mps_pkg::MV_STRAIGHT;
  endfunction

  // Clockwise heading change of a move, in degrees
  function int heading_degrees(mps_pkg::move_t m);
    case (m)
      mps_pkg::MV_RIGHT: return 90;
      mps_pkg::MV_BACK:  return 180;
      mps_pkg::MV_LEFT:  return 270;
      default:           return 0;
    endcase
  endfunction

  // Net move of a detour: into the dead end, turn around, and out again
  function mps_pkg::move_t fold_turns(mps_pkg::move_t a, mps_pkg::move_t b);
    int net;
    net = (heading_degrees(a) + 180 + heading_degrees(b)) % 360;
    case (net)
      90:      return mps_pkg::MV_RIGHT;
      180:     return mps_pkg::MV_BACK;
      270:     return mps_pkg::MV_LEFT;
      default: return mps_pkg::MV_STRAIGHT;
    endcase
  endfunction

  // Fold the leftmost interior back move, close the gap, rescan until none is left
  function void fold_path();
    bit folded;
    int p;
    folded = 1'b1;
    while (folded) begin
      folded = 1'b0;
      for (p = 1; p + 1 < path_len && !folded; p++) begin
        if (path_moves[p] == mps_pkg::MV_BACK) begin
          path_moves[p-1] = fold_turns(path_moves[p-1], path_moves[p+1]);
          for (int k = p; k + 2 < path_len; k++) path_moves[k] = path_moves[k+2];
          path_len -= 2;
          folded = 1'b1;
        end
      end
    end
  endfunction

  // Apply an accepted command word and queue the reply it owes
  function void note_command(logic [1:0] cmd, mps_pkg::move_t mv, logic [6:0] idx);
    path_reply_t r;
    r.move_read = mps_pkg::MV_NONE;
    case (cmd)
      mps_pkg::CMD_RECORD: begin
        if (path_len >= mps_pkg::MAX_MOVES_DEF) begin
          dropped_flag = 1'b1;
        end else begin
          path_moves[path_len] = mv;
          path_len++;
        end
      end
      mps_pkg::CMD_SIMPLIFY: fold_path();
      mps_pkg::CMD_READ: begin
        if (int'(idx) < path_len) r.move_read = {1'b0, path_moves[idx]};
      end
      default: ;
    endcase
    r.length   = 7'(path_len);
    r.overflow = dropped_flag;
    pending.push_back(r);
  endfunction

  task report(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    errors++;
  endtask

  // Compare one reply word against the oldest expectation
  task check_reply(input logic [15:0] word);
    path_reply_t want;
    if (pending.size() == 0) begin
      report($sformatf("reply word 0x%04h with no command pending", word));
      return;
    end
    want = pending.pop_front();
    if (word[2:0] !== want.move_read)
      report($sformatf("move_out got %0d, expected %0d", word[2:0], want.move_read));
    if (word[9:3] !== want.length)
      report($sformatf("path_length got %0d, expected %0d", word[9:3], want.length));
    if (word[10] !== want.overflow)
      report($sformatf("overflowed got %0b, expected %0b", word[10], want.overflow));
  endtask
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mps_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = MAX_MOVES_DEF + 16;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  path_scoreboard sb = new();
  int  burst_left;
  int  issued;
  int  cycle_count;
  bit  press_request;

  maze_path_record_simplify_replay_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("maze_path_record_simplify_replay_core regression: fail");
      $finish;
    end
  end

  // Check every reply word taken at an edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tdata);
  end

  // Receiver: ready runs and stalls of random length, one long hold on request
  initial begin : rx_pattern
    int run_left;
    int stall_left;
    int r;
    bit hold_done;
    run_left   = 0;
    stall_left = 0;
    hold_done  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (press_request && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        m_tready <= 1'b1;
        run_left--;
      end else begin
        r = $urandom_range(0, 9);
        run_left   = (r < 2) ? $urandom_range(80, 200) : $urandom_range(1, 12);
        stall_left = (r < 2) ? 0 : $urandom_range(1, 12);
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_burst();
    if ($urandom_range(0, 9) < 2) return $urandom_range(60, 150);
    return $urandom_range(0, 20);
  endfunction

  function automatic move_t random_move(int back_pct);
    if ($urandom_range(0, 99) < back_pct) return MV_BACK;
    return move_t'($urandom_range(0, 2));
  endfunction

  // Move that turns a trailing back move after m into a back move again
  function automatic move_t mirror_turn(move_t m);
    case (m)
      MV_LEFT:  return MV_RIGHT;
      MV_RIGHT: return MV_LEFT;
      default:  return m;
    endcase
  endfunction

  // Offer one command word, hold it until taken, then maybe pause
  task automatic send_word(input logic [1:0] cmd, input move_t mv, input logic [6:0] idx);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, idx, mv};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(cmd, mv, idx);
    if (cmd != CMD_UNUSED) issued++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
      burst_left = pick_burst();
    end
  endtask

  task automatic record_move(input move_t mv);
    send_word(CMD_RECORD, mv, 7'($urandom_range(0, 127)));
  endtask

  task automatic read_at(input int idx);
    send_word(CMD_READ, move_t'($urandom_range(0, 3)), 7'(idx));
  endtask

  task automatic simplify_cmd();
    send_word(CMD_SIMPLIFY, move_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
  endtask

  // Wander forward: random moves with some back moves, optional fold at the end
  task automatic explore_run();
    int n;
    n = $urandom_range(1, 16);
    if (n > 48 - sb.path_len) n = 48 - sb.path_len;
    for (int i = 0; i < n; i++) begin
      record_move(random_move(25));
      if ($urandom_range(0, 3) == 0) read_at($urandom_range(0, sb.path_len));
    end
    if (n <= 0 || $urandom_range(0, 4) < 3) simplify_cmd();
  endtask

  // Back out of a dead end: a back move, then moves that undo the path so the
  // fold cascades down the store; now and then a random move breaks the chain
  task automatic backtrack_run();
    int len;
    int pred;
    int k;
    len = sb.path_len;
    if (sb.path_moves[len-1] != MV_BACK && len <= 61) begin
      record_move(MV_BACK);
      pred = len - 1;
    end else begin
      pred = len - 2;
    end
    k = $urandom_range(1, 12);
    if (k > pred + 1) k = pred + 1;
    if (k > 62 - sb.path_len) k = 62 - sb.path_len;
    for (int j = 0; j < k; j++) begin
      if ($urandom_range(0, 7) == 0) record_move(random_move(25));
      else record_move(mirror_turn(sb.path_moves[pred-j]));
    end
    if ($urandom_range(0, 4) != 0) simplify_cmd();
    repeat ($urandom_range(1, 4)) read_at($urandom_range(0, sb.path_len));
  endtask

  // Replay part of the path, plus one read anywhere in the index range
  task automatic sweep_reads();
    int step;
    step = $urandom_range(1, 4);
    for (int i = $urandom_range(0, 3); i <= sb.path_len; i += step) read_at(i);
    read_at($urandom_range(0, 127));
  endtask

  initial begin : stimulus
    int  r;
    bit  press_done;
    press_done    = 1'b0;
    press_request = 1'b0;
    issued        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = pick_burst();

    // Empty store, unused command, then a detour with a leading back move
    read_at(0);
    simplify_cmd();
    send_word(CMD_UNUSED, MV_BACK, 7'd127);
    record_move(MV_BACK);
    record_move(MV_STRAIGHT);
    record_move(MV_BACK);
    record_move(MV_RIGHT);
    for (int i = 0; i < 4; i++) read_at(i);
    read_at(4);
    read_at(64);
    read_at(127);
    simplify_cmd();
    read_at(0);
    read_at(1);
    // Back move between two turns folds, leading back move stays put
    record_move(MV_BACK);
    record_move(MV_LEFT);
    simplify_cmd();
    read_at(2);
    send_word(CMD_UNUSED, MV_STRAIGHT, 7'd0);

    // Random episodes of exploring, backing out, replay and noise
    while (issued < 1620) begin
      if (!press_done && issued >= 300) begin
        press_done    = 1'b1;
        press_request = 1'b1;
        burst_left    = 80;
      end
      r = $urandom_range(0, 99);
      if (r < 8 && sb.path_len < 56)
        send_word(2'($urandom_range(0, 3)), move_t'($urandom_range(0, 3)),
                  7'($urandom_range(0, 127)));
      else if (r < 14)
        sweep_reads();
      else if (sb.path_len >= 3 && (sb.path_len > 30 ? r < 70 : r < 35))
        backtrack_run();
      else
        explore_run();
    end

    // Fill the store, fold a full path, then overrun it
    while (sb.path_len < MAX_MOVES_DEF) record_move(random_move(30));
    read_at(MAX_MOVES_DEF - 1);
    read_at(MAX_MOVES_DEF);
    simplify_cmd();
    sweep_reads();
    while (sb.path_len < MAX_MOVES_DEF) record_move(random_move(30));
    repeat (3) record_move(random_move(30));
    read_at(0);
    read_at(MAX_MOVES_DEF - 1);
    read_at(127);
    simplify_cmd();
    read_at(0);

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("maze_path_record_simplify_replay_core regression: pass");
    else
      $display("maze_path_record_simplify_replay_core regression: fail");
    $finish;
  end

endmodule
